// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and codes shared by the first-fit heap allocator modules.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ZERO    = 3'd1;
	localparam logic [2:0] ST_NOSPACE = 3'd2;
	localparam logic [2:0] ST_NOBLOCK = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	localparam logic CFG_HEAP_BASE  = 1'b0;
	localparam logic CFG_HEAP_BYTES = 1'b1;

	typedef struct packed {
		logic        action;
		logic [26:0] request_bytes;
		logic [31:0] release_address;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] data_address;
	} out_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_SCAN_EV, S_SHIFT_CHK, S_SHIFT_WR, S_SPLIT_B,
		S_MERGE_RD, S_MERGE_EV, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_RES, OP_SCAN_RD, OP_ADV, OP_HIT, OP_SPLIT_PREP,
		OP_SHIFT_RD, OP_SHIFT_WR, OP_SPLIT_A, OP_SPLIT_B, OP_APPEND,
		OP_MERGE_INIT, OP_MERGE_RD, OP_MERGE_EV, OP_MERGE_END
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] res;
	} dp_cmd_t;

	typedef struct packed {
		logic is_release;
		logic zero_req;
		logic addr_zero;
		logic at_end;
		logic found;
		logic e_used;
		logic exact;
		logic fits;
		logic full;
		logic no_space;
		logic shift_more;
		logic merge_end;
	} dp_stat_t;

endpackage

// ===== hw/rtl/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for table walk, split shift, growth and merge pass.
// ----------------------------------------------------------------------------
module ffha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ffha_pkg::dp_stat_t stat,
	output ffha_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import ffha_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		cmd.res = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = OP_LOAD;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.is_release) begin
					if (stat.addr_zero) begin
						cmd.op = OP_RES;
						cmd.res = ST_OK;
						state_d = S_DONE;
					end else if (stat.at_end) begin
						cmd.op = OP_RES;
						cmd.res = ST_NOBLOCK;
						state_d = S_DONE;
					end else if (stat.found) begin
						cmd.op = OP_MERGE_INIT;
						state_d = S_MERGE_RD;
					end else begin
						cmd.op = OP_SCAN_RD;
						state_d = S_SCAN_EV;
					end
				end else if (stat.zero_req) begin
					cmd.op = OP_RES;
					cmd.res = ST_ZERO;
					state_d = S_DONE;
				end else if (stat.at_end) begin
					state_d = S_DONE;
					if (stat.no_space) begin
						cmd.op = OP_RES;
						cmd.res = ST_NOSPACE;
					end else if (stat.full) begin
						cmd.op = OP_RES;
						cmd.res = ST_FULL;
					end else begin
						cmd.op = OP_APPEND;
					end
				end else begin
					cmd.op = OP_SCAN_RD;
					state_d = S_SCAN_EV;
				end
			end
			S_SCAN_EV: begin
				if (!stat.is_release && !stat.e_used && stat.exact) begin
					cmd.op = OP_HIT;
					state_d = S_DONE;
				end else if (!stat.is_release && !stat.e_used && stat.fits) begin
					if (stat.full) begin
						cmd.op = OP_RES;
						cmd.res = ST_FULL;
						state_d = S_DONE;
					end else begin
						cmd.op = OP_SPLIT_PREP;
						state_d = S_SHIFT_CHK;
					end
				end else begin
					cmd.op = OP_ADV;
					state_d = S_CHK;
				end
			end
			S_SHIFT_CHK: begin
				if (stat.shift_more) begin
					cmd.op = OP_SHIFT_RD;
					state_d = S_SHIFT_WR;
				end else begin
					cmd.op = OP_SPLIT_A;
					state_d = S_SPLIT_B;
				end
			end
			S_SHIFT_WR: begin
				cmd.op = OP_SHIFT_WR;
				state_d = S_SHIFT_CHK;
			end
			S_SPLIT_B: begin
				cmd.op = OP_SPLIT_B;
				state_d = S_DONE;
			end
			S_MERGE_RD: begin
				if (stat.merge_end) begin
					cmd.op = OP_MERGE_END;
					state_d = S_DONE;
				end else begin
					cmd.op = OP_MERGE_RD;
					state_d = S_MERGE_EV;
				end
			end
			S_MERGE_EV: begin
				cmd.op = OP_MERGE_EV;
				state_d = S_MERGE_RD;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

// ===== hw/rtl/ffha_dp.sv =====
// ----------------------------------------------------------------------------
// ffha_dp
// Block table memory, walk offsets, break, configuration and result.
// ----------------------------------------------------------------------------
module ffha_dp #(
	parameter int MAX_BLOCKS   = 64,
	parameter int HEADER_BYTES = 12,
	parameter int OFFSET_BITS  = 26
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  ffha_pkg::in_t      item,
	input  ffha_pkg::dp_cmd_t  cmd,
	output ffha_pkg::dp_stat_t stat,
	output ffha_pkg::out_t     result
);
	import ffha_pkg::*;

	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int OB = OFFSET_BITS;
	localparam int EW = OB + 1;
	localparam int XW = 34;

	logic [EW-1:0] mem [MAX_BLOCKS];
	logic [EW-1:0] rdata_q;

	logic          action_q;
	logic [27:0]   size_q;
	logic [31:0]   rel_addr_q;
	logic [CW-1:0] idx_q, r_q, w_q, fidx_q, count_q;
	logic [OB-1:0] off_q, brk_q, s_q, p_size_q;
	logic          p_used_q, pv_q;
	logic [31:0]   base_q;
	logic [26:0]   hbytes_q;
	logic [2:0]    status_q;
	logic [31:0]   daddr_q;

	logic [OB-1:0] rd_size;
	logic          rd_used, e_used;
	logic [XW-1:0] size_x, total_x, s_x, grown_x;
	logic [31:0]   data_off;
	logic [27:0]   req_x, req_rnd;
	logic          we;
	logic [AW-1:0] wa, ra;
	logic [EW-1:0] wd;

	assign rd_size  = rdata_q[OB-1:0];
	assign rd_used  = rdata_q[OB];
	assign e_used   = rd_used && (r_q != fidx_q);
	assign size_x   = XW'(size_q);
	assign total_x  = size_x + XW'(HEADER_BYTES);
	assign s_x      = XW'(rd_size);
	assign grown_x  = XW'(brk_q) + total_x;
	assign data_off = base_q + 32'(off_q) + 32'(HEADER_BYTES);
	assign req_x    = {1'b0, item.request_bytes};
	assign req_rnd  = (req_x[1:0] != 2'b00) ? {req_x[27:2] + 26'd1, 2'b00} : req_x;

	assign stat.is_release = action_q;
	assign stat.zero_req   = (size_q == '0);
	assign stat.addr_zero  = (rel_addr_q == '0);
	assign stat.at_end     = (idx_q == count_q);
	assign stat.found      = (data_off == rel_addr_q);
	assign stat.e_used     = rd_used;
	assign stat.exact      = (size_x == s_x);
	assign stat.fits       = (total_x <= s_x);
	assign stat.full       = (count_q == CW'(MAX_BLOCKS));
	assign stat.no_space   = (grown_x >= XW'(hbytes_q)) || (grown_x >= (XW'(1) << OB));
	assign stat.shift_more = (r_q > idx_q);
	assign stat.merge_end  = (r_q == count_q);

	always_comb begin
		we = 1'b0;
		wa = idx_q[AW-1:0];
		wd = rdata_q;
		ra = idx_q[AW-1:0];
		case (cmd.op)
			OP_HIT: begin
				we = 1'b1;
				wd = {1'b1, rd_size};
			end
			OP_SHIFT_RD, OP_MERGE_RD: begin
				ra = r_q[AW-1:0];
			end
			OP_SHIFT_WR: begin
				we = 1'b1;
				wa = AW'(r_q + CW'(1));
			end
			OP_SPLIT_A: begin
				we = 1'b1;
				wa = AW'(idx_q + CW'(1));
				wd = {1'b0, OB'(XW'(s_q) - total_x)};
			end
			OP_SPLIT_B: begin
				we = 1'b1;
				wd = {1'b1, OB'(size_q)};
			end
			OP_APPEND: begin
				we = 1'b1;
				wa = count_q[AW-1:0];
				wd = {1'b1, OB'(size_q)};
			end
			OP_MERGE_EV: begin
				we = pv_q && !(!p_used_q && !e_used);
				wa = w_q[AW-1:0];
				wd = {p_used_q, p_size_q};
			end
			OP_MERGE_END: begin
				we = 1'b1;
				wa = w_q[AW-1:0];
				wd = {p_used_q, p_size_q};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_q   <= 1'b0;
			size_q     <= '0;
			rel_addr_q <= '0;
			idx_q      <= '0;
			r_q        <= '0;
			w_q        <= '0;
			fidx_q     <= '0;
			count_q    <= '0;
			off_q      <= '0;
			brk_q      <= '0;
			s_q        <= '0;
			p_size_q   <= '0;
			p_used_q   <= 1'b0;
			pv_q       <= 1'b0;
			base_q     <= '0;
			hbytes_q   <= '0;
			status_q   <= ST_OK;
			daddr_q    <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_HEAP_BASE) begin
					base_q <= cfg_data;
				end else begin
					hbytes_q <= cfg_data[26:0];
				end
			end
			case (cmd.op)
				OP_LOAD: begin
					action_q   <= item.action;
					size_q     <= req_rnd;
					rel_addr_q <= item.release_address;
					idx_q      <= '0;
					off_q      <= '0;
				end
				OP_RES: begin
					status_q <= cmd.res;
					daddr_q  <= '0;
				end
				OP_ADV: begin
					off_q <= OB'(XW'(off_q) + XW'(HEADER_BYTES) + s_x);
					idx_q <= idx_q + CW'(1);
				end
				OP_HIT: begin
					status_q <= ST_OK;
					daddr_q  <= data_off;
				end
				OP_SPLIT_PREP: begin
					s_q <= rd_size;
					r_q <= count_q - CW'(1);
				end
				OP_SHIFT_WR: begin
					r_q <= r_q - CW'(1);
				end
				OP_SPLIT_B: begin
					count_q  <= count_q + CW'(1);
					status_q <= ST_OK;
					daddr_q  <= data_off;
				end
				OP_APPEND: begin
					count_q  <= count_q + CW'(1);
					brk_q    <= OB'(grown_x);
					status_q <= ST_OK;
					daddr_q  <= base_q + 32'(brk_q) + 32'(HEADER_BYTES);
				end
				OP_MERGE_INIT: begin
					fidx_q <= idx_q;
					r_q    <= '0;
					w_q    <= '0;
					pv_q   <= 1'b0;
				end
				OP_MERGE_EV: begin
					if (pv_q && !p_used_q && !e_used) begin
						p_size_q <= OB'(XW'(p_size_q) + XW'(HEADER_BYTES) + s_x);
					end else begin
						if (pv_q) begin
							w_q <= w_q + CW'(1);
						end
						p_size_q <= rd_size;
						p_used_q <= e_used;
						pv_q     <= 1'b1;
					end
					r_q <= r_q + CW'(1);
				end
				OP_MERGE_END: begin
					count_q  <= w_q + CW'(1);
					status_q <= ST_OK;
					daddr_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign result.status       = status_q;
	assign result.data_address = daddr_q;

endmodule

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with block splitting, break growth and coalescing.
// ----------------------------------------------------------------------------
// One request at a time: start is taken when busy is low, and the result
// shows on result for the one cycle that done is high; the receiver cannot
// stall it. The table sits in a single-port-write memory with a registered
// read, so the walk reads each block it visits and then evaluates it. A
// split moves each later block up one entry in turn, and a release adds a
// merge pass over every table entry. Write the configuration only while
// busy is low.
`include "assert_macros.svh"

module first_fit_heap_allocator #(
	parameter int MAX_BLOCKS   = 64,
	parameter int HEADER_BYTES = 12,
	parameter int OFFSET_BITS  = 26
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [31:0]    cfg_data,
	input  logic           start,
	input  ffha_pkg::in_t  item,
	output logic           busy,
	output logic           done,
	output ffha_pkg::out_t result
);
	import ffha_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ffha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ffha_dp #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES),
		.OFFSET_BITS  (OFFSET_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

	`ASSERT_IMPLY(a_done_busy, clk, arst_n, done, busy)
	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_IMPLY(a_fail_zero, clk, arst_n, done && (result.status != ST_OK),
		result.data_address == '0)

endmodule
